// ===== hdl/utwm_pkg.sv =====
// ----------------------------------------------------------------------------
// utwm_pkg
// Shared types and constants of the UTF-8 text width meter.
// ----------------------------------------------------------------------------
package utwm_pkg;

  localparam int GLYPH_COUNT_DEF = 256;
  localparam int SUM_BITS_DEF    = 16;

  localparam int CP_BITS     = 31;
  localparam int GLYPH_BASE  = 32;
  localparam int OUT_BITS    = 16;

  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] LEAD2_MSK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG = 8'hC0;
  localparam logic [7:0] LEAD3_MSK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG = 8'hE0;
  localparam logic [7:0] LEAD4_MSK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG = 8'hF0;
  localparam logic [7:0] LEAD5_MSK = 8'hFC;
  localparam logic [7:0] LEAD5_TAG = 8'hF8;
  localparam logic [7:0] LEAD6_MSK = 8'hFE;
  localparam logic [7:0] LEAD6_TAG = 8'hFC;

  localparam logic       REQ_LOAD = 1'b0;
  localparam logic       REQ_TEXT = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_TILDE  = 2'd2;

  typedef struct packed {
    logic [CP_BITS-1:0] acc;
    logic [2:0]         brem;
    logic               tilde;
    logic               fmt;
    logic [1:0]         stop;
  } dec_state_t;

  typedef struct packed {
    logic               add;
    logic [CP_BITS-1:0] cp;
  } glyph_req_t;

endpackage

// ===== hdl/utwm_req_if.sv =====
// ----------------------------------------------------------------------------
// utwm_req_if
// Input channel: table loads and text bytes with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface utwm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] glyph_index;
  logic [6:0] glyph_width;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, req_type, glyph_index, glyph_width, text_byte,
                  last_byte, input ready);
  modport sink (input valid, req_type, glyph_index, glyph_width, text_byte,
                last_byte, output ready);
endinterface

// ===== hdl/utwm_res_if.sv =====
// ----------------------------------------------------------------------------
// utwm_res_if
// Result channel: measured width and status of one string.
// ----------------------------------------------------------------------------
interface utwm_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] text_width;
  logic [1:0]  status;

  modport source (output valid, text_width, status, input ready);
  modport sink (input valid, text_width, status, output ready);
endinterface

// ===== hdl/utf8_text_width_meter.sv =====
// ----------------------------------------------------------------------------
// utf8_text_width_meter
// Decodes UTF-8 text and sums glyph widths from a loaded width table.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the input is not stalled, loads and text bytes alike.
// The table read is registered in rd_r with the stage-1 flags as a byte is
// accepted; the add from rd_r then feeds the sum and, for a final byte, the output register.
// Input stalls only while a result waits untaken and the next string's end is held.
// Reset is synchronous and clears the decoder, the sum and the output valid.
// The width table is not cleared; entries read before being loaded are undefined.
module utf8_text_width_meter #(
  parameter int GLYPH_COUNT = utwm_pkg::GLYPH_COUNT_DEF,
  parameter int SUM_BITS    = utwm_pkg::SUM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  utwm_req_if.sink   in_req,
  utwm_res_if.source out_res
);
  import utwm_pkg::*;

  localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int WB = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;

  logic [6:0]          mem [GLYPH_COUNT];
  logic [6:0]          rd_r;

  dec_state_t          dec_r;
  dec_state_t          dec_nxt;
  glyph_req_t          glyph;
  logic [1:0]          res_status;

  logic                s1_valid_r;
  logic                s1_add_r;
  logic                s1_last_r;
  logic [1:0]          s1_status_r;

  logic [SUM_BITS-1:0] sum_r;
  logic [SUM_BITS-1:0] sum_nxt;
  logic [SUM_BITS:0]   sum_full;
  logic [SUM_BITS-1:0] sum_sat;
  logic [WB-1:0]       sum_ext;

  logic                out_valid_r;
  logic [15:0]         out_width_r;
  logic [1:0]          out_status_r;

  logic                advance;
  logic                acc_any;
  logic                acc_text;
  logic                acc_load;
  logic [31:0]         cp_off;
  logic                cp_in_table;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_ok;

  utwm_decode u_decode (
    .cur        (dec_r),
    .text_byte  (in_req.text_byte),
    .last_byte  (in_req.last_byte),
    .nxt        (dec_nxt),
    .glyph      (glyph),
    .res_status (res_status)
  );

  assign advance  = !(s1_valid_r && s1_last_r && out_valid_r && !out_res.ready);
  assign in_req.ready = advance;
  assign acc_any  = in_req.valid && advance;
  assign acc_text = acc_any && (in_req.req_type == REQ_TEXT);
  assign acc_load = acc_any && (in_req.req_type == REQ_LOAD);

  assign cp_off      = 32'(glyph.cp) - 32'(GLYPH_BASE);
  assign cp_in_table = (glyph.cp >= CP_BITS'(GLYPH_BASE)) && (cp_off < 32'(GLYPH_COUNT));
  assign rd_addr     = cp_in_table ? AW'(cp_off) : '0;
  assign wr_ok       = 32'(in_req.glyph_index) < 32'(GLYPH_COUNT);
  assign wr_addr     = AW'(in_req.glyph_index);

  always_ff @(posedge clk) begin
    if (acc_load && wr_ok) begin
      mem[wr_addr] <= in_req.glyph_width;
    end
    if (acc_text && glyph.add) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_add_r   <= 1'b0;
      s1_last_r  <= 1'b0;
    end else if (advance) begin
      if (acc_text) begin
        dec_r <= dec_nxt;
      end
      s1_valid_r <= acc_text;
      s1_add_r   <= acc_text && glyph.add;
      s1_last_r  <= acc_text && in_req.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && acc_text) begin
      s1_status_r <= res_status;
    end
  end

  assign sum_full = {1'b0, sum_r} + (s1_add_r ? (SUM_BITS+1)'({1'b0, rd_r} + 8'd1)
                                              : (SUM_BITS+1)'(0));
  assign sum_sat  = sum_full[SUM_BITS] ? '1 : sum_full[SUM_BITS-1:0];
  assign sum_ext  = WB'(sum_sat);

  always_comb begin
    sum_nxt = sum_r;
    if (advance && s1_valid_r) begin
      sum_nxt = s1_last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      if (advance && s1_valid_r && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && s1_last_r) begin
      out_width_r  <= (sum_ext > WB'(16'hFFFF)) ? 16'hFFFF : sum_ext[15:0];
      out_status_r <= s1_status_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.text_width = out_width_r;
  assign out_res.status     = out_status_r;

  a_stall_has_result : assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> (out_valid_r && s1_valid_r && s1_last_r))
    else $error("Input stalled without a pending result.");

  a_sum_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && s1_last_r) |=> (sum_r == '0))
    else $error("Width sum not cleared after a result.");

  a_state_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (acc_text && in_req.last_byte) |=> (dec_r == '0))
    else $error("Decoder state not cleared at end of string.");

  a_status_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_BAD ||
                     out_status_r == ST_TILDE))
    else $error("Illegal status code on result.");

endmodule

// ===== hdl/utwm_decode.sv =====
// ----------------------------------------------------------------------------
// utwm_decode
// Per-byte UTF-8 decoder with tilde escapes and format mode tracking.
// ----------------------------------------------------------------------------
module utwm_decode (
  input  utwm_pkg::dec_state_t cur,
  input  logic [7:0]           text_byte,
  input  logic                 last_byte,
  output utwm_pkg::dec_state_t nxt,
  output utwm_pkg::glyph_req_t glyph,
  output logic [1:0]           res_status
);
  import utwm_pkg::*;

  always_comb begin
    logic               go_dec;
    logic               done;
    logic [CP_BITS-1:0] cp;
    dec_state_t         s;

    s      = cur;
    go_dec = 1'b0;
    done   = 1'b0;
    cp     = '0;
    glyph  = '0;

    if (cur.stop == ST_OK) begin
      go_dec = 1'b1;
      if (cur.tilde) begin
        s.tilde = 1'b0;
        if (text_byte == CH_LT || text_byte == CH_GT) begin
          s.fmt  = 1'b0;
          go_dec = 1'b0;
        end else if (text_byte == CH_BANG) begin
          go_dec = 1'b0;
        end else if (text_byte == CH_TILDE) begin
          glyph.add = ~cur.fmt;
          glyph.cp  = CP_BITS'(CH_TILDE);
          go_dec    = 1'b0;
        end else begin
          s.fmt = ~cur.fmt;
        end
      end

      if (go_dec) begin
        if (cur.brem != 3'd0) begin
          if ((text_byte & CONT_MASK) != CONT_TAG) begin
            s.stop = ST_BAD;
          end else begin
            s.acc  = {cur.acc[CP_BITS-7:0], text_byte[5:0]};
            s.brem = cur.brem - 3'd1;
            if (s.brem == 3'd0) begin
              done = 1'b1;
              cp   = s.acc;
            end
          end
        end else begin
          priority if (text_byte[7] == 1'b0) begin
            done = 1'b1;
            cp   = CP_BITS'(text_byte);
          end else if ((text_byte & LEAD2_MSK) == LEAD2_TAG) begin
            s.acc  = CP_BITS'(text_byte[4:0]);
            s.brem = 3'd1;
          end else if ((text_byte & LEAD3_MSK) == LEAD3_TAG) begin
            s.acc  = CP_BITS'(text_byte[3:0]);
            s.brem = 3'd2;
          end else if ((text_byte & LEAD4_MSK) == LEAD4_TAG) begin
            s.acc  = CP_BITS'(text_byte[2:0]);
            s.brem = 3'd3;
          end else if ((text_byte & LEAD5_MSK) == LEAD5_TAG) begin
            s.acc  = CP_BITS'(text_byte[1:0]);
            s.brem = 3'd4;
          end else if ((text_byte & LEAD6_MSK) == LEAD6_TAG) begin
            s.acc  = CP_BITS'(text_byte[0]);
            s.brem = 3'd5;
          end else begin
            s.stop = ST_BAD;
          end
        end

        if (done) begin
          if (cp == CP_BITS'(CH_TILDE)) begin
            s.tilde = 1'b1;
          end else begin
            glyph.add = ~s.fmt;
            glyph.cp  = cp;
          end
        end
      end
    end

    if (last_byte && s.stop == ST_OK) begin
      if (s.brem != 3'd0) begin
        s.stop = ST_BAD;
      end else if (s.tilde) begin
        s.stop = ST_TILDE;
      end
    end
    res_status = s.stop;

    if (last_byte) begin
      nxt = '0;
    end else begin
      nxt = s;
    end
  end

endmodule
